/* rtl/core/i2cram_pkg.sv */
// ----------------------------------------------------------------------------
// i2cram_pkg: shared types and constants of the i2c register access master
// word layouts of the channels, op codes, bus segment kinds and their lengths
// ----------------------------------------------------------------------------
package i2cram_pkg;

   // op codes of a request word
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // r/w bit merged into the device address byte
   localparam logic [7:0] ADDR_WRITE_BIT = 8'h00;
   localparam logic [7:0] ADDR_READ_BIT  = 8'h01;

   // bit of a byte that goes out first
   localparam logic [7:0] BYTE_MSB = 8'h80;

   typedef logic [3:0] seg_kind_type;
   typedef logic [3:0] seg_index_type;
   typedef logic [4:0] seg_offset_type;

   localparam seg_kind_type SEG_START   = 4'd0;
   localparam seg_kind_type SEG_WADDR_W = 4'd1;
   localparam seg_kind_type SEG_WADDR_R = 4'd2;
   localparam seg_kind_type SEG_WREG    = 4'd3;
   localparam seg_kind_type SEG_WDATA   = 4'd4;
   localparam seg_kind_type SEG_ACKIN   = 4'd5;
   localparam seg_kind_type SEG_RBYTE   = 4'd6;
   localparam seg_kind_type SEG_NACKOUT = 4'd7;
   localparam seg_kind_type SEG_STOP    = 4'd8;

   // index of the final segment of each transaction
   localparam seg_index_type WRITE_LAST_SEG = 4'd7;
   localparam seg_index_type READ_LAST_SEG  = 4'd10;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] reg_addr;
      logic [7:0] wr_data;
      logic       sda_in;
   } req_word_type;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       nack;
   } rsp_word_type;

   typedef logic [7:0] csr_word_type;

   // segment kind at a position of the write or read sequence
   function automatic seg_kind_type seg_kind(input logic is_read, input seg_index_type idx);
      seg_kind_type kind;
      kind = SEG_STOP;
      if (is_read) begin
         case (idx)
            4'd0:    kind = SEG_START;
            4'd1:    kind = SEG_WADDR_W;
            4'd2:    kind = SEG_ACKIN;
            4'd3:    kind = SEG_WREG;
            4'd4:    kind = SEG_ACKIN;
            4'd5:    kind = SEG_START;
            4'd6:    kind = SEG_WADDR_R;
            4'd7:    kind = SEG_ACKIN;
            4'd8:    kind = SEG_RBYTE;
            4'd9:    kind = SEG_NACKOUT;
            default: kind = SEG_STOP;
         endcase
      end else begin
         case (idx)
            4'd0:    kind = SEG_START;
            4'd1:    kind = SEG_WADDR_W;
            4'd2:    kind = SEG_ACKIN;
            4'd3:    kind = SEG_WREG;
            4'd4:    kind = SEG_ACKIN;
            4'd5:    kind = SEG_WDATA;
            4'd6:    kind = SEG_ACKIN;
            default: kind = SEG_STOP;
         endcase
      end
      return kind;
   endfunction

   // ticks in a segment, minus one
   function automatic seg_offset_type seg_last_offset(input seg_kind_type kind);
      seg_offset_type last;
      case (kind)
         SEG_START:   last = 5'd3;
         SEG_ACKIN:   last = 5'd3;
         SEG_RBYTE:   last = 5'd24;
         SEG_NACKOUT: last = 5'd2;
         SEG_STOP:    last = 5'd2;
         default:     last = 5'd23;
      endcase
      return last;
   endfunction

endpackage

/* rtl/core/i2cram_channel_if.sv */
// ----------------------------------------------------------------------------
// i2cram_channel_if: valid/ready channel
// carries one word of the given type from source to sink
// ----------------------------------------------------------------------------
interface i2cram_channel_if #(
   parameter type word_type = logic
);
   logic     valid;
   logic     ready;
   word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/i2c_register_access_master.sv */
// ----------------------------------------------------------------------------
// i2c_register_access_master: bit-banged i2c register read/write sequencer
// one request word is one pin tick; one response word reports the pins after it
// ----------------------------------------------------------------------------
// Every request word is one tick of the bus timing (one pin action) and gives
// exactly one response word with the scl/sda levels to drive afterwards.
// While idle, op write latches reg_addr/wr_data and runs start, address+w,
// register, data, stop over 91 ticks; op read runs start, address+w,
// register, repeated start, address+r, one received byte, nack, stop over
// 123 ticks. The tick that carries the command is the first tick of the
// transaction, and commands are ignored while busy. sda_in is sampled on ack
// ticks (any high ack sets the sticky nack flag, cleared by a new command)
// and on the receive ticks of a read, shifting read_data in msb first.
// One word per clock cycle, unless the response stalls. The sequencer state is
// updated in the cycle a word is taken and the response sits in an output
// register, so a new word is accepted whenever the response register is empty
// or being drained in the same cycle. The user writes the device address byte
// (reset 0xd0) over the csr channel only while idle; the block does not check.
// ----------------------------------------------------------------------------
module i2c_register_access_master (
   input logic clock,
   input logic reset,
   i2cram_channel_if.sink   req_ch,
   i2cram_channel_if.source rsp_ch,
   i2cram_channel_if.sink   csr_ch
);

   // configuration
   logic [7:0] dev_addr_ff;

   // sequencer state
   logic                       busy_ff,  busy_in;
   logic                       is_read_ff, is_read_in;
   i2cram_pkg::seg_index_type  seg_ff,   seg_in;
   i2cram_pkg::seg_offset_type off_ff,   off_in;
   logic [1:0]                 phase_ff, phase_in;   // pin phase within a bit
   logic [2:0]                 bit_ff,   bit_in;     // bit within a byte
   logic [7:0]                 reg_ff,   reg_in;
   logic [7:0]                 wdata_ff, wdata_in;
   logic [7:0]                 rx_ff,    rx_in;
   logic                       scl_ff,   scl_in;
   logic                       sda_ff,   sda_in;
   logic                       nack_ff,  nack_in;

   // response register
   logic                       rsp_valid_ff, rsp_valid_in;
   i2cram_pkg::rsp_word_type   rsp_data_ff,  rsp_data_in;

   logic req_take;

   // tick view of the current word
   logic                       start;
   logic                       act_busy;
   logic                       act_read;
   i2cram_pkg::seg_index_type  cur_seg;
   i2cram_pkg::seg_offset_type cur_off;
   logic [1:0]                 cur_phase;
   logic [2:0]                 cur_bit;
   i2cram_pkg::seg_kind_type   kind;
   logic                       seg_end;
   logic                       last_tick;
   logic [7:0]                 tx_byte;
   logic                       tx_bit;
   logic                       done;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // a command from idle starts the sequence on this very tick
   assign start    = !busy_ff && ((req_ch.data.op == i2cram_pkg::OP_WRITE) ||
                                  (req_ch.data.op == i2cram_pkg::OP_READ));
   assign act_busy = busy_ff || start;
   assign act_read = start ? (req_ch.data.op == i2cram_pkg::OP_READ) : is_read_ff;
   assign cur_seg   = start ? '0 : seg_ff;
   assign cur_off   = start ? '0 : off_ff;
   assign cur_phase = start ? '0 : phase_ff;
   assign cur_bit   = start ? '0 : bit_ff;

   assign kind      = i2cram_pkg::seg_kind(act_read, cur_seg);
   assign seg_end   = (cur_off == i2cram_pkg::seg_last_offset(kind));
   assign last_tick = seg_end && (cur_seg == (act_read ? i2cram_pkg::READ_LAST_SEG
                                                       : i2cram_pkg::WRITE_LAST_SEG));
   assign done      = act_busy && last_tick;

   // byte shifted out by an address, register or data segment
   always_comb begin
      case (kind)
         i2cram_pkg::SEG_WADDR_W: tx_byte = dev_addr_ff | i2cram_pkg::ADDR_WRITE_BIT;
         i2cram_pkg::SEG_WADDR_R: tx_byte = dev_addr_ff | i2cram_pkg::ADDR_READ_BIT;
         i2cram_pkg::SEG_WREG:    tx_byte = start ? req_ch.data.reg_addr : reg_ff;
         default:                 tx_byte = start ? req_ch.data.wr_data : wdata_ff;
      endcase
   end
   // msb first
   assign tx_bit = |((tx_byte << cur_bit) & i2cram_pkg::BYTE_MSB);

   always_comb begin
      busy_in    = busy_ff;
      is_read_in = is_read_ff;
      seg_in     = seg_ff;
      off_in     = off_ff;
      phase_in   = phase_ff;
      bit_in     = bit_ff;
      reg_in     = reg_ff;
      wdata_in   = wdata_ff;
      rx_in      = rx_ff;
      scl_in     = scl_ff;
      sda_in     = sda_ff;
      nack_in    = nack_ff;

      if (start) begin
         is_read_in = act_read;
         reg_in     = req_ch.data.reg_addr;
         wdata_in   = req_ch.data.wr_data;
         nack_in    = 1'b0;
      end

      if (act_busy) begin
         // pin action of this tick
         case (kind)
            i2cram_pkg::SEG_START: begin
               case (cur_off[1:0])
                  2'd0:    sda_in = 1'b1;
                  2'd1:    scl_in = 1'b1;
                  2'd2:    sda_in = 1'b0;
                  default: scl_in = 1'b0;
               endcase
            end
            i2cram_pkg::SEG_ACKIN: begin
               case (cur_off[1:0])
                  2'd0:    sda_in  = 1'b1;
                  2'd1:    scl_in  = 1'b1;
                  2'd2:    nack_in = nack_in | req_ch.data.sda_in;
                  default: scl_in  = 1'b0;
               endcase
            end
            i2cram_pkg::SEG_RBYTE: begin
               // release sda once, then eight high/sample/low bit cells
               if (cur_off == '0) begin
                  sda_in = 1'b1;
               end else begin
                  case (cur_phase)
                     2'd0:    scl_in = 1'b1;
                     2'd1:    rx_in  = {rx_ff[6:0], req_ch.data.sda_in};
                     default: scl_in = 1'b0;
                  endcase
               end
            end
            i2cram_pkg::SEG_NACKOUT: begin
               case (cur_off[1:0])
                  2'd0:    sda_in = 1'b1;
                  2'd1:    scl_in = 1'b1;
                  default: scl_in = 1'b0;
               endcase
            end
            i2cram_pkg::SEG_STOP: begin
               case (cur_off[1:0])
                  2'd0:    sda_in = 1'b0;
                  2'd1:    scl_in = 1'b1;
                  default: sda_in = 1'b1;
               endcase
            end
            default: begin
               // transmit byte: data/high/low per bit
               case (cur_phase)
                  2'd0:    sda_in = tx_bit;
                  2'd1:    scl_in = 1'b1;
                  default: scl_in = 1'b0;
               endcase
            end
         endcase

         // advance position
         if (seg_end) begin
            seg_in   = cur_seg + 4'd1;
            off_in   = '0;
            phase_in = '0;
            bit_in   = '0;
         end else begin
            off_in   = cur_off + 5'd1;
            phase_in = cur_phase;
            bit_in   = cur_bit;
            // the receive segment opens with one release tick outside the bit cells
            if ((kind != i2cram_pkg::SEG_RBYTE) || (cur_off != '0)) begin
               if (cur_phase == 2'd2) begin
                  phase_in = '0;
                  bit_in   = cur_bit + 3'd1;
               end else begin
                  phase_in = cur_phase + 2'd1;
               end
            end
         end

         busy_in = !last_tick;
         if (last_tick) begin
            seg_in = '0;
            off_in = '0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_take) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.scl       = scl_in;
         rsp_data_in.sda       = sda_in;
         rsp_data_in.busy_res  = busy_in;
         rsp_data_in.done_res  = done;
         rsp_data_in.read_data = rx_in;
         rsp_data_in.nack      = nack_in;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state and visible levels
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff  <= 8'd208;
         busy_ff      <= 1'b0;
         is_read_ff   <= 1'b0;
         seg_ff       <= '0;
         off_ff       <= '0;
         phase_ff     <= '0;
         bit_ff       <= '0;
         rx_ff        <= '0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         nack_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            dev_addr_ff <= csr_ch.data;
         end
         if (req_take) begin
            busy_ff    <= busy_in;
            is_read_ff <= is_read_in;
            seg_ff     <= seg_in;
            off_ff     <= off_in;
            phase_ff   <= phase_in;
            bit_ff     <= bit_in;
            rx_ff      <= rx_in;
            scl_ff     <= scl_in;
            sda_ff     <= sda_in;
            nack_ff    <= nack_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // latched command bytes and response word
   always_ff @(posedge clock) begin
      if (req_take) begin
         reg_ff   <= reg_in;
         wdata_ff <= wdata_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* sim/i2c_register_access_master_tb.sv */
// ----------------------------------------------------------------------------
// i2c_register_access_master_tb: self-checking bench of the i2c register master
// drives pin-tick words carrying commands and sampled sda, predicts every
// response word from a cycle-exact model of the bus sequence and compares it
// field by field; the device address is changed between phases, and the
// sender and receiver idle at random in several mixes
// ----------------------------------------------------------------------------
module i2c_register_access_master_tb;

   // op code 3 has no meaning and acts as a plain tick
   localparam logic [1:0] OP_SPARE = 2'd3;

   localparam int WRITE_TICKS    = 91;
   localparam int READ_TICKS     = 123;
   localparam int PHASE_COUNT    = 6;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 5000;

   // how sda_in behaves over one transaction
   typedef enum int {SDA_LOW, SDA_HIGH, SDA_RANDOM} sda_pattern_type;

   logic clock;
   logic reset;

   i2cram_channel_if #(.word_type(i2cram_pkg::req_word_type)) req_ch ();
   i2cram_channel_if #(.word_type(i2cram_pkg::rsp_word_type)) rsp_ch ();
   i2cram_channel_if #(.word_type(i2cram_pkg::csr_word_type)) csr_ch ();

   i2c_register_access_master DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // words waiting to be sent, and pin levels waiting to come back
   i2cram_pkg::req_word_type tick_words_pending[$];
   i2cram_pkg::rsp_word_type pin_levels_due[$];

   int send_gap_pct  = 0;
   int rsp_stall_pct = 0;
   bit req_taken     = 1'b0;
   bit csr_seen      = 1'b0;
   int mismatch_count = 0;
   int quiet_cycles   = 0;

   // mirror of the sequencer, starting from its reset state
   logic [7:0] dev_addr  = 8'd208;
   bit         xfer_busy = 1'b0;
   bit         xfer_read = 1'b0;
   int         xfer_tick = 0;
   logic [7:0] cmd_reg   = 8'h00;
   logic [7:0] cmd_data  = 8'h00;
   logic [7:0] rx_byte   = 8'h00;
   logic       bus_scl   = 1'b1;
   logic       bus_sda   = 1'b1;
   logic       ack_fault = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // segment kind and offset of a tick within the write or read sequence
   task automatic locate_tick(input bit rd, input int t,
                              output i2cram_pkg::seg_kind_type kind,
                              output int offset, output bit final_tick);
      kind = i2cram_pkg::SEG_STOP;
      offset = 0;
      if (t < 4) begin
         kind = i2cram_pkg::SEG_START;   offset = t;
      end else if (t < 28) begin
         kind = i2cram_pkg::SEG_WADDR_W; offset = t - 4;
      end else if (t < 32) begin
         kind = i2cram_pkg::SEG_ACKIN;   offset = t - 28;
      end else if (t < 56) begin
         kind = i2cram_pkg::SEG_WREG;    offset = t - 32;
      end else if (t < 60) begin
         kind = i2cram_pkg::SEG_ACKIN;   offset = t - 56;
      end else if (!rd) begin
         if (t < 84) begin
            kind = i2cram_pkg::SEG_WDATA; offset = t - 60;
         end else if (t < 88) begin
            kind = i2cram_pkg::SEG_ACKIN; offset = t - 84;
         end else begin
            kind = i2cram_pkg::SEG_STOP;  offset = t - 88;
         end
      end else begin
         // repeated start, address with read bit, one byte in, nack, stop
         if (t < 64) begin
            kind = i2cram_pkg::SEG_START;   offset = t - 60;
         end else if (t < 88) begin
            kind = i2cram_pkg::SEG_WADDR_R; offset = t - 64;
         end else if (t < 92) begin
            kind = i2cram_pkg::SEG_ACKIN;   offset = t - 88;
         end else if (t < 117) begin
            kind = i2cram_pkg::SEG_RBYTE;   offset = t - 92;
         end else if (t < 120) begin
            kind = i2cram_pkg::SEG_NACKOUT; offset = t - 117;
         end else begin
            kind = i2cram_pkg::SEG_STOP;    offset = t - 120;
         end
      end
      final_tick = (t == (rd ? READ_TICKS : WRITE_TICKS) - 1);
   endtask

   // one pin action: drive scl, drive sda or sample sda
   task automatic drive_pins(input i2cram_pkg::seg_kind_type kind, input int offset,
                             input logic sda_in);
      int         k;
      int         p;
      logic [7:0] tx_byte;
      case (kind)
         i2cram_pkg::SEG_START: begin
            case (offset)
               0:       bus_sda = 1'b1;
               1:       bus_scl = 1'b1;
               2:       bus_sda = 1'b0;
               default: bus_scl = 1'b0;
            endcase
         end
         i2cram_pkg::SEG_ACKIN: begin
            case (offset)
               0:       bus_sda = 1'b1;
               1:       bus_scl = 1'b1;
               2:       ack_fault = ack_fault | sda_in;
               default: bus_scl = 1'b0;
            endcase
         end
         i2cram_pkg::SEG_RBYTE: begin
            if (offset == 0) begin
               bus_sda = 1'b1;
            end else begin
               p = (offset - 1) % 3;
               if (p == 0) bus_scl = 1'b1;
               else if (p == 1) rx_byte = {rx_byte[6:0], sda_in};
               else bus_scl = 1'b0;
            end
         end
         i2cram_pkg::SEG_NACKOUT: begin
            case (offset)
               0:       bus_sda = 1'b1;
               1:       bus_scl = 1'b1;
               default: bus_scl = 1'b0;
            endcase
         end
         i2cram_pkg::SEG_STOP: begin
            case (offset)
               0:       bus_sda = 1'b0;
               1:       bus_scl = 1'b1;
               default: bus_sda = 1'b1;
            endcase
         end
         default: begin
            // outgoing byte, msb first, three ticks per bit
            case (kind)
               i2cram_pkg::SEG_WADDR_W: tx_byte = dev_addr | i2cram_pkg::ADDR_WRITE_BIT;
               i2cram_pkg::SEG_WADDR_R: tx_byte = dev_addr | i2cram_pkg::ADDR_READ_BIT;
               i2cram_pkg::SEG_WREG:    tx_byte = cmd_reg;
               default:                 tx_byte = cmd_data;
            endcase
            k = (offset / 3) & 7;
            p = offset % 3;
            if (p == 0) bus_sda = ((tx_byte & (i2cram_pkg::BYTE_MSB >> k)) != 8'h00);
            else if (p == 1) bus_scl = 1'b1;
            else bus_scl = 1'b0;
         end
      endcase
   endtask

   // advances the mirror by one accepted tick and gives the pins after it
   task automatic advance_sequencer(input i2cram_pkg::req_word_type w,
                                    output i2cram_pkg::rsp_word_type r);
      i2cram_pkg::seg_kind_type kind;
      int                       offset;
      bit                       final_tick;
      logic                     done;
      done = 1'b0;
      // a command only starts from idle; while busy it is ignored
      if (!xfer_busy && (w.op == i2cram_pkg::OP_WRITE || w.op == i2cram_pkg::OP_READ)) begin
         xfer_busy = 1'b1;
         xfer_read = (w.op == i2cram_pkg::OP_READ);
         cmd_reg   = w.reg_addr;
         cmd_data  = w.wr_data;
         ack_fault = 1'b0;
         xfer_tick = 0;
      end
      if (xfer_busy) begin
         locate_tick(xfer_read, xfer_tick, kind, offset, final_tick);
         drive_pins(kind, offset, w.sda_in);
         if (final_tick) begin
            xfer_busy = 1'b0;
            done      = 1'b1;
            xfer_tick = 0;
         end else begin
            xfer_tick = xfer_tick + 1;
         end
      end
      r.scl       = bus_scl;
      r.sda       = bus_sda;
      r.busy_res  = xfer_busy;
      r.done_res  = done;
      r.read_data = rx_byte;
      r.nack      = ack_fault;
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // a whole command: the command word, the rest of its ticks, then idle ticks;
   // stray commands in the middle must be ignored
   task automatic queue_command(input logic [1:0] op, input logic [7:0] reg_addr,
                                input logic [7:0] wr_data, input sda_pattern_type pattern,
                                input bit stray_cmds, input int idle_after);
      i2cram_pkg::req_word_type w;
      int                       n;
      n = (op == i2cram_pkg::OP_READ) ? READ_TICKS : WRITE_TICKS;
      for (int i = 0; i < n + idle_after; i++) begin
         w.reg_addr = 8'($urandom_range(0, 255));
         w.wr_data  = 8'($urandom_range(0, 255));
         if (i == 0) begin
            w.op       = op;
            w.reg_addr = reg_addr;
            w.wr_data  = wr_data;
         end else if (i >= n) begin
            w.op = $urandom_range(0, 1) ? i2cram_pkg::OP_TICK : OP_SPARE;
         end else if (stray_cmds && $urandom_range(0, 3) == 0) begin
            w.op = 2'($urandom_range(0, 3));
         end else begin
            w.op = i2cram_pkg::OP_TICK;
         end
         case (pattern)
            SDA_LOW:  w.sda_in = 1'b0;
            SDA_HIGH: w.sda_in = 1'b1;
            default:  w.sda_in = 1'($urandom_range(0, 1));
         endcase
         tick_words_pending.push_back(w);
      end
   endtask

   task automatic queue_random_command();
      sda_pattern_type pattern;
      case ($urandom_range(0, 3))
         0:       pattern = SDA_LOW;
         1:       pattern = SDA_HIGH;
         default: pattern = SDA_RANDOM;
      endcase
      queue_command($urandom_range(0, 1) ? i2cram_pkg::OP_READ : i2cram_pkg::OP_WRITE,
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), pattern,
                    1'($urandom_range(0, 1)), int'($urandom_range(0, 3)));
   endtask

   // fully random words, may start a command at any point
   task automatic queue_noise(input int n);
      i2cram_pkg::req_word_type w;
      for (int i = 0; i < n; i++) begin
         w.op       = 2'($urandom_range(0, 3));
         w.reg_addr = 8'($urandom_range(0, 255));
         w.wr_data  = 8'($urandom_range(0, 255));
         w.sda_in   = 1'($urandom_range(0, 1));
         tick_words_pending.push_back(w);
      end
   endtask

   // sampled at the rising edge: nothing queued, nothing offered, nothing due
   task automatic wait_drained();
      do @(posedge clock);
      while (tick_words_pending.size() != 0 || req_ch.valid || pin_levels_due.size() != 0);
   endtask

   // keeps ticking until the mirror reports no running transaction
   task automatic settle_idle();
      i2cram_pkg::req_word_type w;
      wait_drained();
      while (xfer_busy) begin
         w = '0;
         w.op = i2cram_pkg::OP_TICK;
         for (int i = 0; i < 8; i++) tick_words_pending.push_back(w);
         wait_drained();
      end
   endtask

   task automatic write_device_address(input i2cram_pkg::csr_word_type value);
      @(negedge clock);
      csr_seen = 1'b0;
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      @(negedge clock);
      while (!csr_seen) @(negedge clock);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0:       begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
         1:       begin send_gap_pct = 79; rsp_stall_pct = 0;  end
         2:       begin send_gap_pct = 0;  rsp_stall_pct = 79; end
         default: begin send_gap_pct = 34; rsp_stall_pct = 34; end
      endcase
   endtask

   // driver: offers the next pending word once the previous one is taken
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_ch.valid || req_taken) begin
            if (tick_words_pending.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
               req_ch.valid <= 1'b1;
               req_ch.data  <= tick_words_pending.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // monitor: checks responses, predicts accepted words, tracks csr writes
   always @(posedge clock) begin : monitor
      i2cram_pkg::rsp_word_type want;
      i2cram_pkg::rsp_word_type next_levels;
      if (!reset) begin
         req_taken = req_ch.valid && req_ch.ready;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pin_levels_due.size() == 0) begin
               $display("%0t: response word expected none, got %h", $time, rsp_ch.data);
               mismatch_count++;
            end else begin
               want = pin_levels_due.pop_front();
               check_field("scl", 8'(want.scl), 8'(rsp_ch.data.scl));
               check_field("sda", 8'(want.sda), 8'(rsp_ch.data.sda));
               check_field("busy_res", 8'(want.busy_res), 8'(rsp_ch.data.busy_res));
               check_field("done_res", 8'(want.done_res), 8'(rsp_ch.data.done_res));
               check_field("read_data", want.read_data, rsp_ch.data.read_data);
               check_field("nack", 8'(want.nack), 8'(rsp_ch.data.nack));
            end
         end
         if (req_taken) begin
            advance_sequencer(req_ch.data, next_levels);
            pin_levels_due.push_back(next_levels);
         end
         if (csr_ch.valid && csr_ch.ready) begin
            dev_addr = csr_ch.data;
            csr_seen = 1'b1;
         end
         if (req_taken || (rsp_ch.valid && rsp_ch.ready) || (csr_ch.valid && csr_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.data  = '0;
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      @(posedge clock);

      // directed: idle ticks, extremes of register and data, acks low and high,
      // commands while busy, and a read right behind a write
      set_idling(0);
      queue_command(i2cram_pkg::OP_TICK, 8'hff, 8'hff, SDA_HIGH, 1'b0, 0);
      queue_command(OP_SPARE, 8'h00, 8'h00, SDA_LOW, 1'b0, 0);
      queue_command(i2cram_pkg::OP_WRITE, 8'hff, 8'h00, SDA_LOW, 1'b0, 2);
      queue_command(i2cram_pkg::OP_READ, 8'h00, 8'hff, SDA_HIGH, 1'b1, 1);
      queue_command(i2cram_pkg::OP_WRITE, 8'h00, 8'hff, SDA_RANDOM, 1'b1, 0);
      queue_command(i2cram_pkg::OP_READ, 8'ha5, 8'h5a, SDA_RANDOM, 1'b0, 3);
      settle_idle();

      // random phases, each with a device address write and an idling mix
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         repeat (SETTLE_CYCLES) @(posedge clock);
         case (phase)
            0:       write_device_address(8'd0);
            1:       write_device_address(8'd254);
            default: write_device_address(8'($urandom_range(0, 254)));
         endcase
         set_idling(phase % 4);
         queue_random_command();
         queue_noise(3);
         settle_idle();
      end

      wait_drained();
      repeat (20) @(negedge clock);
      if (pin_levels_due.size() != 0) begin
         $display("%0t: %0d response words expected, got none", $time, pin_levels_due.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
